// ===== rtl/dma_source_chain_channel_unit_assert.svh =====
// ----------------------------------------------------------------------------
// dma_source_chain_channel_unit_assert.svh
// Assertion macros used by the channel checker.
// ----------------------------------------------------------------------------
`ifndef DMA_SOURCE_CHAIN_CHANNEL_UNIT_ASSERT_SVH
`define DMA_SOURCE_CHAIN_CHANNEL_UNIT_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted
`define DSC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked during reset as well
`define DSC_ASSERT_NXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/dsc_pkg.sv =====
// ----------------------------------------------------------------------------
// dsc_pkg
// Types, codes and constants of the source-chain DMA channel.
// ----------------------------------------------------------------------------
package dsc_pkg;

    // Default depth of the address stack
    localparam int STACK_ENTRIES_DEF = 2;

    // Request operations
    localparam logic [2:0] OP_WR_CTRL  = 3'd0;
    localparam logic [2:0] OP_WR_MADR  = 3'd1;
    localparam logic [2:0] OP_WR_QWC   = 3'd2;
    localparam logic [2:0] OP_WR_TADR  = 3'd3;
    localparam logic [2:0] OP_WR_STACK = 3'd4;
    localparam logic [2:0] OP_QWORD    = 3'd5;
    localparam logic [2:0] OP_TAG      = 3'd6;
    localparam logic [2:0] OP_COMPLETE = 3'd7;

    // Error codes
    localparam logic [3:0] ERR_OK       = 4'd0;
    localparam logic [3:0] ERR_BAD_BITS = 4'd1;
    localparam logic [3:0] ERR_DIR      = 4'd2;
    localparam logic [3:0] ERR_MODE     = 4'd3;
    localparam logic [3:0] ERR_CHANGED  = 4'd4;
    localparam logic [3:0] ERR_BAD_SP   = 4'd5;
    localparam logic [3:0] ERR_BUSY     = 4'd6;
    localparam logic [3:0] ERR_SPR      = 4'd7;
    localparam logic [3:0] ERR_INDEX    = 4'd8;
    localparam logic [3:0] ERR_ZERO_QWC = 4'd9;
    localparam logic [3:0] ERR_TAG_SPR  = 4'd10;

    // Tag ids
    localparam logic [2:0] TAG_REFE = 3'd0;
    localparam logic [2:0] TAG_CNT  = 3'd1;
    localparam logic [2:0] TAG_NEXT = 3'd2;
    localparam logic [2:0] TAG_REF  = 3'd3;
    localparam logic [2:0] TAG_REFS = 3'd4;
    localparam logic [2:0] TAG_CALL = 3'd5;
    localparam logic [2:0] TAG_RET  = 3'd6;

    // Channel modes
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_CHAIN  = 2'd1;

    // Masks and control layout
    localparam logic [31:0] ADDR_MASK  = 32'h7fff_fff0;
    localparam logic [31:0] C_WRITABLE = 32'hffff_01fd;
    localparam logic [31:0] C_START    = 32'h0000_0100;
    localparam logic [31:0] QW_BYTES   = 32'd16;
    localparam int          START_BIT  = 8;
    localparam int          TIE_BIT    = 7;
    localparam int          SPR_BIT    = 31;
    localparam int          DIR_BIT    = 0;

    // One request as it enters the step logic
    typedef struct packed {
        logic [2:0]  operation;
        logic [1:0]  stack_slot;
        logic [31:0] write_value;
        logic [31:0] tag_low_word;
        logic [31:0] tag_high_word;
    } t_req;

    // Channel registers other than the address stack
    typedef struct packed {
        logic [31:0] ctrl;
        logic [31:0] madr;
        logic [15:0] qwc;
        logic [31:0] tadr;
        logic [1:0]  depth;
        logic        eap;
    } t_chan;

    // Status of one step
    typedef struct packed {
        logic [3:0] err;
        logic       done;
        logic       rst_cont;
    } t_status;

endpackage

// ===== rtl/dsc_ifs.sv =====
// ----------------------------------------------------------------------------
// dsc_ifs
// Request and result channels of the source-chain DMA channel.
// ----------------------------------------------------------------------------
interface dsc_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [1:0]  stack_slot;
    logic [31:0] write_value;
    logic [31:0] tag_low_word;
    logic [31:0] tag_high_word;

    modport source (output valid, operation, stack_slot, write_value,
                    tag_low_word, tag_high_word, input ready);
    modport sink   (input valid, operation, stack_slot, write_value,
                    tag_low_word, tag_high_word, output ready);
endinterface

interface dsc_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  error_code;
    logic        transfer_complete;
    logic        reset_continuation;
    logic [31:0] control_readback;
    logic [31:0] memory_address_readback;
    logic [15:0] count_readback;
    logic [31:0] tag_address_readback;
    logic [31:0] stack_entry0_readback;
    logic [31:0] stack_entry1_readback;

    modport source (output valid, error_code, transfer_complete, reset_continuation,
                    control_readback, memory_address_readback, count_readback,
                    tag_address_readback, stack_entry0_readback,
                    stack_entry1_readback, input ready);
    modport sink   (input valid, error_code, transfer_complete, reset_continuation,
                    control_readback, memory_address_readback, count_readback,
                    tag_address_readback, stack_entry0_readback,
                    stack_entry1_readback, output ready);
endinterface

// ===== rtl/dsc_step.sv =====
// ----------------------------------------------------------------------------
// dsc_step
// Next-state and status logic for one channel request.
// ----------------------------------------------------------------------------
module dsc_step #(
    parameter int STACK_ENTRIES = dsc_pkg::STACK_ENTRIES_DEF
) (
    input  dsc_pkg::t_req                       i_req,
    input  dsc_pkg::t_chan                      i_cur,
    input  logic [STACK_ENTRIES-1:0][31:0]      i_stack,
    input  logic                                i_from_mem_only,
    output dsc_pkg::t_chan                      o_nxt,
    output logic [STACK_ENTRIES-1:0][31:0]      o_stack,
    output dsc_pkg::t_status                    o_status
);

    localparam logic [1:0] SE_W = 2'(STACK_ENTRIES);

    logic [31:0] v;
    logic [31:0] low;
    logic [31:0] high;
    logic        active;
    logic [2:0]  tag_id;
    logic [15:0] tag_qwc;
    logic [31:0] inl;
    logic [31:0] after;
    logic [31:0] tag_addr;
    logic        push_ok;
    logic        pop_ok;
    logic [31:0] pop_val;
    logic [1:0]  ctrl_mode;

    assign v         = i_req.write_value;
    assign low       = i_req.tag_low_word;
    assign high      = i_req.tag_high_word;
    assign active    = i_cur.ctrl[dsc_pkg::START_BIT];
    assign tag_id    = low[30:28];
    assign tag_qwc   = low[15:0];
    assign inl       = i_cur.tadr + dsc_pkg::QW_BYTES;
    assign after     = inl + {12'd0, tag_qwc, 4'd0};
    assign tag_addr  = high & dsc_pkg::ADDR_MASK;
    assign push_ok   = i_cur.depth < SE_W;
    assign pop_ok    = (i_cur.depth != 2'd0) && (i_cur.depth <= SE_W);
    assign ctrl_mode = v[3:2];

    // Select the top of stack for a return
    always_comb begin
        pop_val = '0;
        for (int k = 0; k < STACK_ENTRIES; k++) begin
            if (i_cur.depth == 2'(k + 1)) begin
                pop_val = i_stack[k];
            end
        end
    end

    // Evaluate the request
    always_comb begin
        o_nxt    = i_cur;
        o_stack  = i_stack;
        o_status = '{err: dsc_pkg::ERR_OK, done: 1'b0, rst_cont: 1'b0};
        case (i_req.operation)
            dsc_pkg::OP_WR_CTRL: begin
                if ((v & ~dsc_pkg::C_WRITABLE) != 32'd0) begin
                    o_status.err = dsc_pkg::ERR_BAD_BITS;
                end else if (i_from_mem_only && !v[dsc_pkg::DIR_BIT]) begin
                    o_status.err = dsc_pkg::ERR_DIR;
                end else if (ctrl_mode != dsc_pkg::MODE_NORMAL &&
                             ctrl_mode != dsc_pkg::MODE_CHAIN) begin
                    o_status.err = dsc_pkg::ERR_MODE;
                end else if (active) begin
                    if (((i_cur.ctrl ^ v) & ~dsc_pkg::C_START) != 32'd0) begin
                        o_status.err = dsc_pkg::ERR_CHANGED;
                    end else if (!v[dsc_pkg::START_BIT]) begin
                        // Stop the channel
                        o_nxt.ctrl[dsc_pkg::START_BIT] = 1'b0;
                        o_nxt.eap                      = 1'b0;
                        o_status.rst_cont              = 1'b1;
                    end
                end else if (v[5:4] > SE_W) begin
                    o_status.err = dsc_pkg::ERR_BAD_SP;
                end else begin
                    o_nxt.ctrl        = v;
                    o_nxt.depth       = v[5:4];
                    o_nxt.eap         = 1'b0;
                    o_status.rst_cont = 1'b1;
                end
            end
            dsc_pkg::OP_WR_MADR, dsc_pkg::OP_WR_TADR: begin
                if (active) begin
                    o_status.err = dsc_pkg::ERR_BUSY;
                end else if (v[dsc_pkg::SPR_BIT]) begin
                    o_status.err = dsc_pkg::ERR_SPR;
                end else if (i_req.operation == dsc_pkg::OP_WR_MADR) begin
                    o_nxt.madr = v & dsc_pkg::ADDR_MASK;
                end else begin
                    o_nxt.tadr = v & dsc_pkg::ADDR_MASK;
                end
            end
            dsc_pkg::OP_WR_QWC: begin
                if (active) begin
                    o_status.err = dsc_pkg::ERR_BUSY;
                end else begin
                    o_nxt.qwc = v[15:0];
                end
            end
            dsc_pkg::OP_WR_STACK: begin
                if (active) begin
                    o_status.err = dsc_pkg::ERR_BUSY;
                end else if ({1'b0, i_req.stack_slot} >= 3'(STACK_ENTRIES)) begin
                    o_status.err = dsc_pkg::ERR_INDEX;
                end else if (v[dsc_pkg::SPR_BIT]) begin
                    o_status.err = dsc_pkg::ERR_SPR;
                end else begin
                    for (int k = 0; k < STACK_ENTRIES; k++) begin
                        if (i_req.stack_slot == 2'(k)) begin
                            o_stack[k] = v & dsc_pkg::ADDR_MASK;
                        end
                    end
                end
            end
            dsc_pkg::OP_QWORD: begin
                if (i_cur.qwc == 16'd0) begin
                    o_status.err = dsc_pkg::ERR_ZERO_QWC;
                end else begin
                    o_nxt.madr    = i_cur.madr + dsc_pkg::QW_BYTES;
                    o_nxt.qwc     = i_cur.qwc - 16'd1;
                    o_status.done = (i_cur.qwc == 16'd1) &&
                                    (i_cur.eap || i_cur.ctrl[3:2] == dsc_pkg::MODE_NORMAL);
                end
            end
            dsc_pkg::OP_TAG: begin
                if (high[dsc_pkg::SPR_BIT]) begin
                    o_status.err = dsc_pkg::ERR_TAG_SPR;
                end else begin
                    // Load tag field, count and the interrupt-driven end flag
                    o_nxt.ctrl[31:16] = low[31:16];
                    o_nxt.qwc         = tag_qwc;
                    o_nxt.eap         = low[31] & i_cur.ctrl[dsc_pkg::TIE_BIT];
                    case (tag_id)
                        dsc_pkg::TAG_REFE: begin
                            o_nxt.madr = tag_addr;
                            o_nxt.tadr = inl;
                            o_nxt.eap  = 1'b1;
                        end
                        dsc_pkg::TAG_CNT: begin
                            o_nxt.madr = inl;
                            o_nxt.tadr = after;
                        end
                        dsc_pkg::TAG_NEXT: begin
                            o_nxt.madr = inl;
                            o_nxt.tadr = tag_addr;
                        end
                        dsc_pkg::TAG_REF, dsc_pkg::TAG_REFS: begin
                            o_nxt.madr = tag_addr;
                            o_nxt.tadr = inl;
                        end
                        dsc_pkg::TAG_CALL: begin
                            if (push_ok) begin
                                // Push the return address
                                for (int k = 0; k < STACK_ENTRIES; k++) begin
                                    if (i_cur.depth == 2'(k)) begin
                                        o_stack[k] = after;
                                    end
                                end
                                o_nxt.depth     = i_cur.depth + 2'd1;
                                o_nxt.ctrl[5:4] = i_cur.depth + 2'd1;
                                o_nxt.madr      = inl;
                                o_nxt.tadr      = tag_addr;
                            end
                        end
                        dsc_pkg::TAG_RET: begin
                            o_nxt.madr = inl;
                            if (pop_ok) begin
                                o_nxt.depth     = i_cur.depth - 2'd1;
                                o_nxt.ctrl[5:4] = i_cur.depth - 2'd1;
                                o_nxt.tadr      = pop_val;
                            end else begin
                                o_nxt.tadr = after;
                                o_nxt.eap  = 1'b1;
                            end
                        end
                        default: begin
                            o_nxt.madr = inl;
                            o_nxt.tadr = after;
                            o_nxt.eap  = 1'b1;
                        end
                    endcase
                    // Overflowing call always ends the transfer
                    o_status.done = ((tag_id == dsc_pkg::TAG_CALL) && !push_ok) ||
                                    ((o_nxt.qwc == 16'd0) && o_nxt.eap);
                end
            end
            default: begin
                // End-of-transfer event
                o_nxt.ctrl[dsc_pkg::START_BIT] = 1'b0;
                o_nxt.eap                      = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/dma_source_chain_channel_unit.sv =====
// ----------------------------------------------------------------------------
// dma_source_chain_channel_unit
// Source-chain DMA channel: register writes, quadword advance, tag decode.
// ----------------------------------------------------------------------------
// Accepts one request per clock and returns one result per request, in order.
// A request is captured in an input register and evaluated against the channel
// registers; its result lands in the output register once that register is
// empty or being drained, and stays there until ready takes it. Channel
// state is updated in the same cycle the result is registered, so a request
// sees every earlier request's effect. Throughput is one request per cycle
// whenever the result is taken; a waiting result holds the request behind it
// in the input register, and input ready drops once that register is full.
// from_memory_only is set through i_cfg_we and i_cfg_wdata and should change
// only while no request is in flight.
module dma_source_chain_channel_unit #(
    parameter int STACK_ENTRIES = dsc_pkg::STACK_ENTRIES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dsc_in_if.sink     i_in,
    dsc_out_if.source  o_out,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata
);

    logic                             r_in_valid;
    dsc_pkg::t_req                    r_req;
    logic                             r_out_valid;
    dsc_pkg::t_status                 r_status;
    logic                             r_from_mem_only;
    dsc_pkg::t_chan                   r_chan;
    logic [STACK_ENTRIES-1:0][31:0]   r_stack;

    dsc_pkg::t_chan                   n_chan;
    logic [STACK_ENTRIES-1:0][31:0]   n_stack;
    dsc_pkg::t_status                 n_status;
    logic                             advance;
    logic                             fire;

    // Output stage may load when empty or being drained
    assign advance    = !r_out_valid || o_out.ready;
    assign fire       = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    // Hold the configuration bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_from_mem_only <= 1'b1;
        end else if (i_cfg_we) begin
            r_from_mem_only <= i_cfg_wdata;
        end
    end

    // Capture an incoming request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_req <= '{operation:     i_in.operation,
                       stack_slot:    i_in.stack_slot,
                       write_value:   i_in.write_value,
                       tag_low_word:  i_in.tag_low_word,
                       tag_high_word: i_in.tag_high_word};
        end
    end

    dsc_step #(
        .STACK_ENTRIES (STACK_ENTRIES)
    ) u_step (
        .i_req           (r_req),
        .i_cur           (r_chan),
        .i_stack         (r_stack),
        .i_from_mem_only (r_from_mem_only),
        .o_nxt           (n_chan),
        .o_stack         (n_stack),
        .o_status        (n_status)
    );

    // Advance channel state on each evaluated request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan  <= '0;
            r_stack <= '0;
        end else if (fire) begin
            r_chan  <= n_chan;
            r_stack <= n_stack;
        end
    end

    // Result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status <= n_status;
        end
    end

    // Drive the result; readbacks show the registers after the request
    assign o_out.valid                   = r_out_valid;
    assign o_out.error_code              = r_status.err;
    assign o_out.transfer_complete       = r_status.done;
    assign o_out.reset_continuation      = r_status.rst_cont;
    assign o_out.control_readback        = r_chan.ctrl;
    assign o_out.memory_address_readback = r_chan.madr;
    assign o_out.count_readback          = r_chan.qwc;
    assign o_out.tag_address_readback    = r_chan.tadr;
    assign o_out.stack_entry0_readback   = r_stack[0];

    generate
        if (STACK_ENTRIES > 1) begin : g_entry1
            assign o_out.stack_entry1_readback = r_stack[STACK_ENTRIES > 1 ? 1 : 0];
        end else begin : g_no_entry1
            assign o_out.stack_entry1_readback = 32'd0;
        end
    endgenerate

endmodule

// ===== rtl/dsc_checker.sv =====
// ----------------------------------------------------------------------------
// dsc_checker
// Port-level checks of the source-chain DMA channel results.
// ----------------------------------------------------------------------------
`include "dma_source_chain_channel_unit_assert.svh"

module dsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic [3:0]  i_err,
    input logic        i_done,
    input logic        i_rst_cont,
    input logic [31:0] i_ctrl
);

    // Error codes stay within the defined set
    `DSC_ASSERT_IMP(a_err_range, i_clk, i_rst_n, i_out_valid, i_err <= dsc_pkg::ERR_TAG_SPR, "error code out of range")

    // A failed request reports neither completion nor continuation reset
    `DSC_ASSERT_IMP(a_err_quiet, i_clk, i_rst_n, i_out_valid && (i_err != dsc_pkg::ERR_OK), !i_done && !i_rst_cont, "flags raised on error")

    // Only normal or source-chain mode can ever be loaded
    `DSC_ASSERT_IMP(a_mode_legal, i_clk, i_rst_n, i_out_valid, !i_ctrl[3], "illegal mode in control")

    // Reset drops any pending result
    `DSC_ASSERT_NXT(a_rst_flush, i_clk, !i_rst_n, !i_out_valid, "result valid after reset")

endmodule

bind dma_source_chain_channel_unit dsc_checker u_dsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_err       (o_out.error_code),
    .i_done      (o_out.transfer_complete),
    .i_rst_cont  (o_out.reset_continuation),
    .i_ctrl      (o_out.control_readback)
);

// ===== sim/tb_dma_source_chain_channel_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dma_source_chain_channel_unit
// Drives register writes, quadword advances, source-chain tags and completion
// events into one DMA channel, keeps a shadow copy of the channel registers,
// and compares every returned readback with the shadow's prediction.
// ----------------------------------------------------------------------------
module tb_dma_source_chain_channel_unit;
    import dsc_pkg::*;

    localparam int         STACK_DEPTH    = STACK_ENTRIES_DEF;
    localparam int         REQUEST_TARGET = 1400;
    localparam int         CYCLE_LIMIT    = 500000;
    localparam int         REPORT_LIMIT   = 10;
    localparam logic [2:0] TAG_END        = 3'd7;

    // One readback as returned by the channel
    typedef struct packed {
        logic [3:0]  err;
        logic        done;
        logic        rst_cont;
        logic [31:0] ctrl;
        logic [31:0] madr;
        logic [15:0] qwc;
        logic [31:0] tadr;
        logic [31:0] stk0;
        logic [31:0] stk1;
    } t_readback;

    // Shadow of the channel registers plus the queue of predicted readbacks
    class channel_shadow;
        bit          from_mem_only;
        logic [31:0] ctrl;
        logic [31:0] madr;
        logic [15:0] qwc;
        logic [31:0] tadr;
        logic [31:0] ret_stack [STACK_DEPTH];
        logic [1:0]  depth;
        bit          eap;
        t_readback   readback_queue [$];
        int          fail_count;

        function new();
            from_mem_only = 1'b1;
            ctrl = '0;
            madr = '0;
            qwc = '0;
            tadr = '0;
            foreach (ret_stack[i]) ret_stack[i] = '0;
            depth = '0;
            eap = 1'b0;
            fail_count = 0;
        endfunction

        function int pending();
            return readback_queue.size();
        endfunction

        function logic [31:0] stack_slot_value(int idx);
            return (idx < STACK_DEPTH) ? ret_stack[idx] : 32'd0;
        endfunction

        // Decode one tag; return 1 when the transfer ends with it
        function bit decode_tag(logic [31:0] lo, logic [31:0] hi);
            logic [31:0] inl_addr;
            logic [31:0] skip_addr;
            logic [31:0] target;
            inl_addr    = tadr + QW_BYTES;
            skip_addr   = inl_addr + {12'd0, lo[15:0], 4'd0};
            target      = hi & ADDR_MASK;
            ctrl[31:16] = lo[31:16];
            qwc         = lo[15:0];
            eap         = lo[31] && ctrl[TIE_BIT];
            case (lo[30:28])
                TAG_REFE: begin
                    madr = target;
                    tadr = inl_addr;
                    eap  = 1'b1;
                end
                TAG_CNT: begin
                    madr = inl_addr;
                    tadr = skip_addr;
                end
                TAG_NEXT: begin
                    madr = inl_addr;
                    tadr = target;
                end
                TAG_REF, TAG_REFS: begin
                    madr = target;
                    tadr = inl_addr;
                end
                TAG_CALL: begin
                    // full stack: only the tag field, count and end flag move
                    if (depth >= STACK_DEPTH) return 1'b1;
                    ret_stack[depth] = skip_addr;
                    depth     = depth + 2'd1;
                    ctrl[5:4] = depth;
                    madr      = inl_addr;
                    tadr      = target;
                end
                TAG_RET: begin
                    madr = inl_addr;
                    if (depth == 0 || depth > STACK_DEPTH) begin
                        // empty stack: skip the inline data and end after this packet
                        tadr = skip_addr;
                        eap  = 1'b1;
                    end else begin
                        depth     = depth - 2'd1;
                        tadr      = ret_stack[depth];
                        ctrl[5:4] = depth;
                    end
                end
                default: begin
                    madr = inl_addr;
                    tadr = skip_addr;
                    eap  = 1'b1;
                end
            endcase
            return (qwc == 0) && eap;
        endfunction

        // Apply one accepted request and queue its readback
        function void take_request(t_req r);
            t_readback   res;
            logic [31:0] v;
            logic        active;
            v      = r.write_value;
            active = ctrl[START_BIT];
            res    = '0;
            res.err = ERR_OK;
            case (r.operation)
                OP_WR_CTRL: begin
                    if ((v & ~C_WRITABLE) != 0) res.err = ERR_BAD_BITS;
                    else if (from_mem_only && !v[DIR_BIT]) res.err = ERR_DIR;
                    else if (v[3:2] != MODE_NORMAL && v[3:2] != MODE_CHAIN) res.err = ERR_MODE;
                    else if (active) begin
                        if (((ctrl ^ v) & ~C_START) != 0) res.err = ERR_CHANGED;
                        else if (!v[START_BIT]) begin
                            ctrl[START_BIT] = 1'b0;
                            eap = 1'b0;
                            res.rst_cont = 1'b1;
                        end
                    end else if (v[5:4] > STACK_DEPTH) res.err = ERR_BAD_SP;
                    else begin
                        ctrl  = v;
                        depth = v[5:4];
                        eap   = 1'b0;
                        res.rst_cont = 1'b1;
                    end
                end
                OP_WR_MADR, OP_WR_TADR: begin
                    if (active) res.err = ERR_BUSY;
                    else if (v[SPR_BIT]) res.err = ERR_SPR;
                    else if (r.operation == OP_WR_MADR) madr = v & ADDR_MASK;
                    else tadr = v & ADDR_MASK;
                end
                OP_WR_QWC: begin
                    if (active) res.err = ERR_BUSY;
                    else qwc = v[15:0];
                end
                OP_WR_STACK: begin
                    if (active) res.err = ERR_BUSY;
                    else if (r.stack_slot >= STACK_DEPTH) res.err = ERR_INDEX;
                    else if (v[SPR_BIT]) res.err = ERR_SPR;
                    else ret_stack[r.stack_slot] = v & ADDR_MASK;
                end
                OP_QWORD: begin
                    if (qwc == 0) res.err = ERR_ZERO_QWC;
                    else begin
                        madr = madr + QW_BYTES;
                        qwc  = qwc - 16'd1;
                        res.done = (qwc == 0) && (eap || ctrl[3:2] == MODE_NORMAL);
                    end
                end
                OP_TAG: begin
                    if (r.tag_high_word[SPR_BIT]) res.err = ERR_TAG_SPR;
                    else res.done = decode_tag(r.tag_low_word, r.tag_high_word);
                end
                default: begin
                    ctrl[START_BIT] = 1'b0;
                    eap = 1'b0;
                end
            endcase
            res.ctrl = ctrl;
            res.madr = madr;
            res.qwc  = qwc;
            res.tadr = tadr;
            res.stk0 = stack_slot_value(0);
            res.stk1 = stack_slot_value(1);
            readback_queue.push_back(res);
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("%0t: %s expected 0x%h, got 0x%h", $time, field, want, got);
            end
        endfunction

        // Match one returned readback against the oldest prediction
        function void check_readback(t_readback got);
            t_readback want;
            if (readback_queue.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("%0t: readback arrived with no request pending", $time);
                return;
            end
            want = readback_queue.pop_front();
            compare("error_code", want.err, got.err);
            compare("transfer_complete", want.done, got.done);
            compare("reset_continuation", want.rst_cont, got.rst_cont);
            compare("control_readback", want.ctrl, got.ctrl);
            compare("memory_address_readback", want.madr, got.madr);
            compare("count_readback", want.qwc, got.qwc);
            compare("tag_address_readback", want.tadr, got.tadr);
            compare("stack_entry0_readback", want.stk0, got.stk0);
            compare("stack_entry1_readback", want.stk1, got.stk1);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    int   cycle_count = 0;
    int   requests_sent = 0;
    int   burst_left = 0;

    dsc_in_if  req_if ();
    dsc_out_if res_if ();

    channel_shadow shadow;

    dma_source_chain_channel_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (req_if),
        .o_out       (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // Clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    // Stall the result side on a random 16-bit ready pattern, redrawn when the position wraps
    logic [15:0] ready_pattern = 16'hffff;
    int          stall_pos = 0;
    always @(negedge clk) begin
        if (stall_pos == 0) begin
            case ($urandom_range(0, 3))
                0: ready_pattern = 16'hffff;
                1: ready_pattern = 16'($urandom);
                2: ready_pattern = 16'($urandom & $urandom);
                default: ready_pattern = 16'($urandom | $urandom);
            endcase
        end
        res_if.ready <= ready_pattern[stall_pos % 16];
        stall_pos = (stall_pos + 1) % 64;
    end

    // Check every readback taken
    always @(posedge clk) begin
        if (rst_n && res_if.valid && res_if.ready)
            shadow.check_readback('{err: res_if.error_code,
                                    done: res_if.transfer_complete,
                                    rst_cont: res_if.reset_continuation,
                                    ctrl: res_if.control_readback,
                                    madr: res_if.memory_address_readback,
                                    qwc: res_if.count_readback,
                                    tadr: res_if.tag_address_readback,
                                    stk0: res_if.stack_entry0_readback,
                                    stk1: res_if.stack_entry1_readback});
    end

    // Watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("dma_source_chain_channel_unit: mismatch");
        $finish;
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'h8000_0000;
            3: return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] addr_value();
        logic [31:0] v;
        v = $urandom;
        if ($urandom_range(0, 9) != 0) v[SPR_BIT] = 1'b0;
        return v;
    endfunction

    // Control word with start set, legal direction and a mostly legal pointer
    function automatic logic [31:0] start_ctrl(logic [1:0] mode);
        logic [31:0] v;
        v = $urandom & C_WRITABLE;
        v[DIR_BIT] = shadow.from_mem_only ? 1'b1 : 1'($urandom_range(0, 1));
        v[3:2] = mode;
        v[5:4] = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, STACK_DEPTH));
        v[START_BIT] = 1'b1;
        return v;
    endfunction

    function automatic logic [31:0] tag_low();
        logic [31:0] lo;
        int          pick;
        lo   = $urandom;
        pick = $urandom_range(0, 11);
        if (pick < 8) lo[30:28] = 3'(pick);
        else if (pick < 10) lo[30:28] = TAG_CALL;
        else lo[30:28] = TAG_RET;
        if ($urandom_range(0, 7) != 0) lo[15:0] = 16'($urandom_range(0, 4));
        return lo;
    endfunction

    function automatic logic [31:0] tag_high();
        logic [31:0] hi;
        hi = $urandom;
        if ($urandom_range(0, 15) != 0) hi[SPR_BIT] = 1'b0;
        return hi;
    endfunction

    // Present one request in bursts with random gaps; hold until accepted
    task automatic send_request(input t_req r);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 4) == 0) begin
                gap = 0;
                burst_left = 40;
            end else begin
                gap = $urandom_range(0, 6);
                burst_left = $urandom_range(1, 16);
            end
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        req_if.valid         <= 1'b1;
        req_if.operation     <= r.operation;
        req_if.stack_slot    <= r.stack_slot;
        req_if.write_value   <= r.write_value;
        req_if.tag_low_word  <= r.tag_low_word;
        req_if.tag_high_word <= r.tag_high_word;
        do @(posedge clk); while (!req_if.ready);
        shadow.take_request(r);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] op, input logic [31:0] v,
                             input logic [1:0] slot);
        t_req r;
        r.operation     = op;
        r.stack_slot    = slot;
        r.write_value   = v;
        r.tag_low_word  = $urandom;
        r.tag_high_word = $urandom;
        send_request(r);
    endtask

    task automatic send_tag(input logic [31:0] lo, input logic [31:0] hi);
        t_req r;
        r.operation     = OP_TAG;
        r.stack_slot    = 2'($urandom);
        r.write_value   = $urandom;
        r.tag_low_word  = lo;
        r.tag_high_word = hi;
        send_request(r);
    endtask

    task automatic send_op(input logic [2:0] op);
        t_req r;
        r.operation     = op;
        r.stack_slot    = 2'($urandom);
        r.write_value   = $urandom;
        r.tag_low_word  = $urandom;
        r.tag_high_word = $urandom;
        send_request(r);
    endtask

    // Drain all results, then change the direction filter
    task automatic set_from_memory_only(input bit value);
        req_if.valid <= 1'b0;
        burst_left = 0;
        while (shadow.pending() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        shadow.from_mem_only = value;
        @(negedge clk);
    endtask

    // Stop an active channel, by control write or by completion event
    task automatic stop_channel();
        if (shadow.ctrl[START_BIT] && $urandom_range(0, 1))
            write_reg(OP_WR_CTRL, shadow.ctrl & ~C_START, 2'd0);
        if (shadow.ctrl[START_BIT])
            send_op(OP_COMPLETE);
    endtask

    // Poke at the registers, mostly while the channel runs
    task automatic meddle();
        case ($urandom_range(0, 3))
            0: write_reg(OP_WR_CTRL, shadow.ctrl, 2'd0);
            1: write_reg(OP_WR_CTRL, shadow.ctrl ^ (32'h1 << $urandom_range(0, 31)), 2'd0);
            2: write_reg(3'($urandom_range(1, 4)), pick_word(), 2'($urandom));
            default: write_reg(OP_WR_CTRL, shadow.ctrl & ~C_START, 2'd0);
        endcase
    endtask

    // Set up a source-chain transfer and walk a run of tags with their data
    task automatic chain_run();
        int n_tags;
        int n_qw;
        stop_channel();
        if ($urandom_range(0, 3) != 0) write_reg(OP_WR_TADR, addr_value(), 2'd0);
        if ($urandom_range(0, 2) == 0) write_reg(OP_WR_MADR, addr_value(), 2'd0);
        if ($urandom_range(0, 2) == 0)
            write_reg(OP_WR_QWC, {16'($urandom), 16'($urandom_range(0, 3))}, 2'd0);
        if ($urandom_range(0, 2) == 0)
            write_reg(OP_WR_STACK, addr_value(),
                      ($urandom_range(0, 5) == 0) ? 2'($urandom) : 2'($urandom_range(0, 1)));
        write_reg(OP_WR_CTRL, start_ctrl(MODE_CHAIN), 2'd0);
        n_tags = $urandom_range(1, 10);
        repeat (n_tags) begin
            send_tag(tag_low(), tag_high());
            n_qw = (shadow.qwc > 4) ? 4 : int'(shadow.qwc);
            if ($urandom_range(0, 7) == 0) n_qw++;
            repeat (n_qw) send_op(OP_QWORD);
            if ($urandom_range(0, 15) == 0) meddle();
        end
    endtask

    // Plain transfer: count, address, start in normal mode, then quadwords
    task automatic normal_run();
        int n_qw;
        stop_channel();
        write_reg(OP_WR_QWC, {16'($urandom), 16'($urandom_range(0, 5))}, 2'd0);
        if ($urandom_range(0, 1)) write_reg(OP_WR_MADR, addr_value(), 2'd0);
        write_reg(OP_WR_CTRL, start_ctrl(MODE_NORMAL), 2'd0);
        n_qw = int'(shadow.qwc) + (($urandom_range(0, 3) == 0) ? 1 : 0);
        if (n_qw > 8) n_qw = 8;
        repeat (n_qw) send_op(OP_QWORD);
    endtask

    task automatic noise_run();
        t_req r;
        repeat ($urandom_range(1, 8)) begin
            r.operation     = 3'($urandom_range(0, 7));
            r.stack_slot    = 2'($urandom);
            r.write_value   = pick_word();
            r.tag_low_word  = pick_word();
            r.tag_high_word = pick_word();
            send_request(r);
        end
    endtask

    // Field extremes, every operation and every error code
    task automatic directed_run();
        write_reg(OP_WR_CTRL, 32'h0000_0002, 2'd0);     // bit outside the writable set
        write_reg(OP_WR_CTRL, 32'h0000_0000, 2'd0);     // direction not from memory
        write_reg(OP_WR_CTRL, 32'h0000_0009, 2'd0);     // reserved mode
        write_reg(OP_WR_CTRL, 32'h0000_0031, 2'd0);     // stack pointer too deep
        write_reg(OP_WR_MADR, 32'h8000_0000, 2'd0);     // scratchpad address
        write_reg(OP_WR_MADR, 32'h7fff_ffff, 2'd0);
        write_reg(OP_WR_QWC, 32'hffff_ffff, 2'd0);
        write_reg(OP_WR_TADR, 32'h7fff_fff0, 2'd0);
        write_reg(OP_WR_STACK, 32'h0000_0000, 2'd2);    // slot out of range
        write_reg(OP_WR_STACK, 32'h8000_0000, 2'd3);    // range wins over scratchpad
        write_reg(OP_WR_STACK, 32'hffff_ffff, 2'd0);
        write_reg(OP_WR_STACK, 32'h1234_5678, 2'd1);
        send_op(OP_QWORD);
        write_reg(OP_WR_QWC, 32'h0000_0000, 2'd0);
        send_op(OP_QWORD);                              // zero count
        write_reg(OP_WR_CTRL, 32'hffff_01e5, 2'd0);     // start chain with a full stack
        write_reg(OP_WR_MADR, 32'h0000_0000, 2'd0);     // busy
        write_reg(OP_WR_CTRL, 32'hffff_01a5, 2'd0);     // changed while active
        send_tag(32'h1000_0001, 32'h8000_0000);         // scratchpad tag
        send_tag(32'h5000_0000, 32'h0000_1000);         // call on a full stack
        send_tag(32'he000_0002, 32'h0000_0000);         // ret with irq, pops
        send_op(OP_QWORD);
        send_op(OP_QWORD);
        send_tag(32'h6000_0000, 32'h0000_0000);         // ret, pops last entry
        send_tag(32'h6000_0000, 32'h0000_0000);         // ret on an empty stack
        send_tag(32'h0000_0001, 32'h7fff_ffff);
        send_tag(32'h1000_ffff, 32'h0000_0000);
        send_tag(32'h2000_0000, 32'h7fff_fff0);
        send_tag(32'h3000_0000, 32'h0000_0010);
        send_tag(32'h4000_0000, 32'h0000_0020);
        send_tag({1'b0, TAG_END, 28'h000_0000}, 32'h0000_0000);
        write_reg(OP_WR_CTRL, shadow.ctrl, 2'd0);        // same value, no effect
        write_reg(OP_WR_CTRL, shadow.ctrl & ~C_START, 2'd0);
        send_op(OP_COMPLETE);
    endtask

    initial begin
        int phase_end;
        clk                  = 1'b0;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = 1'b0;
        req_if.valid         = 1'b0;
        req_if.operation     = OP_WR_CTRL;
        req_if.stack_slot    = 2'd0;
        req_if.write_value   = 32'd0;
        req_if.tag_low_word  = 32'd0;
        req_if.tag_high_word = 32'd0;
        res_if.ready         = 1'b0;
        shadow = new();

        // Hold reset low, then release it
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed_run();

        // Alternate the direction filter across the random phases
        for (int phase = 0; phase < 4; phase++) begin
            set_from_memory_only(phase % 2 == 0 ? 1'b0 : 1'b1);
            phase_end = requests_sent + REQUEST_TARGET / 4;
            while (requests_sent < phase_end) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: chain_run();
                    5, 6: normal_run();
                    7: noise_run();
                    8: meddle();
                    default: begin
                        chain_run();
                        noise_run();
                    end
                endcase
            end
        end

        // Drain and let any stray result show
        req_if.valid <= 1'b0;
        while (shadow.pending() != 0) @(negedge clk);
        repeat (8) @(negedge clk);

        if (shadow.fail_count == 0 && shadow.pending() == 0)
            $display("dma_source_chain_channel_unit: match");
        else
            $display("dma_source_chain_channel_unit: mismatch");
        $finish;
    end

endmodule

// ===== dma_source_chain_channel_unit.f =====
+incdir+rtl
rtl/dsc_pkg.sv
rtl/dsc_ifs.sv
rtl/dsc_step.sv
rtl/dma_source_chain_channel_unit.sv
rtl/dsc_checker.sv
sim/tb_dma_source_chain_channel_unit.sv
